>>> src/track_link_stub_budget_limiter_unit_assert.svh
// Assertion macros for the track link stub budget limiter.
// Used by the port checker; depends on nothing else.
`ifndef TRACK_LINK_STUB_BUDGET_LIMITER_UNIT_ASSERT_SVH
`define TRACK_LINK_STUB_BUDGET_LIMITER_UNIT_ASSERT_SVH

// A property that must hold on every clock edge outside reset.
`define TLSBL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked on every clock edge outside reset.
`define TLSBL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> src/tlsbl_pkg.sv
// Shared types and constants of the track link stub budget limiter.
// Used by the link selector and the top level; depends on nothing.
package tlsbl_pkg;

   // Fixed field widths.
   localparam int BIN_W    = 4;
   localparam int STUB_W   = 6;
   localparam int LINK_W   = 3;
   localparam int BUDGET_W = 12;
   localparam int NRANGE_W = 4;
   localparam int BOUNDS_W = 32;
   localparam int RTABLE_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KILL_ENABLE     = 3'd0,
      REG_SPLIT_BY_CHARGE = 3'd1,
      REG_RANGE_MODE      = 3'd2,
      REG_USE_RANK_MAP    = 3'd3,
      REG_STUB_BUDGET     = 3'd4,
      REG_NUM_RANGES      = 3'd5,
      REG_RANGE_BOUNDS    = 3'd6,
      REG_BIN_RANK_TABLE  = 3'd7
   } csr_reg_type;

   // Register file contents.
   typedef struct packed {
      logic                kill_enable;
      logic                split_by_charge;
      logic                range_mode;
      logic                use_rank_map;
      logic [BUDGET_W-1:0] stub_budget;
      logic [NRANGE_W-1:0] num_ranges;
      logic [BOUNDS_W-1:0] range_upper_bounds;
      logic [RTABLE_W-1:0] bin_rank_table;
   } cfg_type;

   // Outcome of the link choice for one track.
   typedef struct packed {
      logic [LINK_W-1:0] link;
      logic              err;
   } link_sel_type;

endpackage

>>> src/tlsbl_link_select.sv
// Link choice for one track: rank range search, charge split or single link.
// Depends on tlsbl_pkg.
module tlsbl_link_select
   import tlsbl_pkg::*;
#(
   parameter int NUM_QPT_BINS = 16,
   parameter int NUM_LINKS    = 8
) (
   input  cfg_type           cfg,
   input  logic [BIN_W-1:0]  qpt_bin,
   input  logic              positive_charge,
   output link_sel_type      sel
);

   logic [BIN_W-1:0] rank;
   logic             bin_err;
   logic [BIN_W-1:0] hi    [NUM_LINKS];
   logic [BIN_W:0]   lo    [NUM_LINKS];
   logic [NUM_LINKS-1:0] match;
   logic             found;
   logic [LINK_W-1:0] range_link;

   // Rank of the bin, either remapped through the table or the bin itself.
   assign rank    = cfg.use_rank_map ? cfg.bin_rank_table[{qpt_bin, 2'b00} +: BIN_W]
                                     : qpt_bin;
   assign bin_err = ({1'b0, qpt_bin} >= (BIN_W+1)'(NUM_QPT_BINS));

   // Parallel range test; each lower bound is the previous upper bound plus one.
   always_comb begin
      for (int i = 0; i < NUM_LINKS; i++) begin
         hi[i] = cfg.range_upper_bounds[i*BIN_W +: BIN_W];
         if (i == 0) begin
            lo[i] = '0;
         end else begin
            lo[i] = {1'b0, cfg.range_upper_bounds[(i-1)*BIN_W +: BIN_W]} + 1'b1;
         end
         match[i] = (NRANGE_W'(i) < cfg.num_ranges) &&
                    ({1'b0, rank} >= lo[i]) && (rank <= hi[i]);
      end
   end

   // Lowest matching range wins.
   always_comb begin
      found      = 1'b0;
      range_link = '0;
      for (int i = NUM_LINKS - 1; i >= 0; i--) begin
         if (match[i]) begin
            found      = 1'b1;
            range_link = LINK_W'(i);
         end
      end
   end

   // Mode priority: range mode, then charge split, then a single link.
   always_comb begin
      sel.link = '0;
      sel.err  = 1'b0;
      if (cfg.range_mode) begin
         if (bin_err || !found) begin
            sel.err = 1'b1;
         end else begin
            sel.link = range_link;
         end
      end else if (cfg.split_by_charge) begin
         sel.link = positive_charge ? LINK_W'(0) : LINK_W'(1);
      end
   end

endmodule

>>> src/track_link_stub_budget_limiter_unit.sv
// Top level of the track link stub budget limiter: registers, counters, result stage.
// Depends on tlsbl_pkg and tlsbl_link_select.
//
// Channel  Direction  tdata fields (low bit up)                       tlast
// req_     in         qpt_bin[3:0] positive_charge[4] stub_count[10:5] last_track
// rsp_     out        keep[0] link_index[3:1] range_error[4]           event_end
// csr_     in         write enable, register index, write data         -
//
// Unless the output stalls, one track is accepted per cycle and registered the next cycle.
// The link choice, the counter read-add-saturate and the budget compare are combinational.
// Reset clears the registers to their defaults, the link counters and the output valid.
// A stalled result holds in the output register; a new track is taken in the cycle the
// waiting result leaves, so a ready sink sees one result per cycle.
module track_link_stub_budget_limiter_unit
   import tlsbl_pkg::*;
#(
   parameter int NUM_QPT_BINS = 16,
   parameter int NUM_LINKS    = 8,
   parameter int COUNTER_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   // qpt_bin, positive_charge, stub_count, zero fill
   input  logic [15:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // keep, link_index, range_error, zero fill
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
   localparam int SUM_W = ((COUNTER_BITS > BUDGET_W) ? COUNTER_BITS : BUDGET_W) + 1;
   localparam logic [SUM_W-1:0] CTR_MAX = SUM_W'({COUNTER_BITS{1'b1}});

   cfg_type cfg_ff, cfg_in;
   logic [COUNTER_BITS-1:0] ctr_ff [NUM_LINKS];
   logic [COUNTER_BITS-1:0] ctr_in [NUM_LINKS];
   logic        rsp_valid_ff, rsp_valid_in;
   logic        keep_ff, keep_in;
   logic [LINK_W-1:0] link_ff;
   logic        err_ff;
   logic        last_ff;

   logic [BIN_W-1:0]  qpt_bin;
   logic              positive_charge;
   logic [STUB_W-1:0] stub_count;
   logic              req_accept;
   link_sel_type      sel;
   logic [IDX_W-1:0]  idx;
   logic [SUM_W-1:0]  sum;
   logic [COUNTER_BITS-1:0] sat;

   // Input fields.
   assign qpt_bin         = req_tdata[3:0];
   assign positive_charge = req_tdata[4];
   assign stub_count      = req_tdata[10:5];

   // Take a track whenever the output register is empty or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_KILL_ENABLE:     cfg_in.kill_enable        = csr_wdata[0];
            REG_SPLIT_BY_CHARGE: cfg_in.split_by_charge    = csr_wdata[0];
            REG_RANGE_MODE:      cfg_in.range_mode         = csr_wdata[0];
            REG_USE_RANK_MAP:    cfg_in.use_rank_map       = csr_wdata[0];
            REG_STUB_BUDGET:     cfg_in.stub_budget        = csr_wdata[BUDGET_W-1:0];
            REG_NUM_RANGES:      cfg_in.num_ranges         = csr_wdata[NRANGE_W-1:0];
            REG_RANGE_BOUNDS:    cfg_in.range_upper_bounds = csr_wdata[BOUNDS_W-1:0];
            REG_BIN_RANK_TABLE:  cfg_in.bin_rank_table     = csr_wdata[RTABLE_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kill_enable        <= 1'b0;
         cfg_ff.split_by_charge    <= 1'b0;
         cfg_ff.range_mode         <= 1'b0;
         cfg_ff.use_rank_map       <= 1'b0;
         cfg_ff.stub_budget        <= {BUDGET_W{1'b1}};
         cfg_ff.num_ranges         <= NRANGE_W'(1);
         cfg_ff.range_upper_bounds <= BOUNDS_W'(15);
         cfg_ff.bin_rank_table     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Link choice.
   tlsbl_link_select #(
      .NUM_QPT_BINS (NUM_QPT_BINS),
      .NUM_LINKS    (NUM_LINKS)
   ) u_link_select (
      .cfg             (cfg_ff),
      .qpt_bin         (qpt_bin),
      .positive_charge (positive_charge),
      .sel             (sel)
   );

   // Add the stubs to the chosen counter; the compare uses the unsaturated sum.
   assign idx  = sel.link[IDX_W-1:0];
   assign sum  = SUM_W'(ctr_ff[idx]) + SUM_W'(stub_count);
   assign sat  = (sum > CTR_MAX) ? {COUNTER_BITS{1'b1}} : sum[COUNTER_BITS-1:0];
   assign keep_in = !sel.err &&
                    (!cfg_ff.kill_enable || (sum <= SUM_W'(cfg_ff.stub_budget)));

   // Counter update; the last track of an event clears every counter.
   always_comb begin
      for (int i = 0; i < NUM_LINKS; i++) begin
         ctr_in[i] = ctr_ff[i];
         if (req_accept) begin
            if (req_tlast) begin
               ctr_in[i] = '0;
            end else if (!sel.err && (idx == IDX_W'(i))) begin
               ctr_in[i] = sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINKS; i++) begin
            ctr_ff[i] <= '0;
         end
      end else begin
         ctr_ff <= ctr_in;
      end
   end

   // Output register.
   assign rsp_valid_in = req_accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         keep_ff <= keep_in;
         link_ff <= sel.link;
         err_ff  <= sel.err;
         last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, err_ff, link_ff, keep_ff};
   assign rsp_tlast  = last_ff;

endmodule

>>> src/tlsbl_checker.sv
// Port checker for the track link stub budget limiter, bound to the top level.
// Depends on track_link_stub_budget_limiter_unit_assert.svh.
`include "track_link_stub_budget_limiter_unit_assert.svh"

module tlsbl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // A range error never forwards the track and always reports link zero.
   `TLSBL_ASSERT_IMP(a_err_drops, clock, reset, rsp_tvalid && rsp_tdata[4], rsp_tdata[3:0] == 4'd0, "range error with keep or link set")

   // Every accepted track shows a result in the next cycle.
   `TLSBL_ASSERT_IMP(a_accept_result, clock, reset, req_tvalid && req_tready, ##1 rsp_tvalid, "accepted track gave no result")

   // The block takes a track whenever its output register is free to move.
   `TLSBL_ASSERT_IMP(a_ready_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready, "not ready although the result stage is free")

   // A stalled result holds its value.
   `TLSBL_ASSERT_IMP(a_hold, clock, reset, rsp_tvalid && !rsp_tready, ##1 (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "stalled result changed")

endmodule

bind track_link_stub_budget_limiter_unit tlsbl_checker u_tlsbl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
